@@ hdl/jsch_pkg.sv @@
// ----------------------------------------------------------------------------
// jsch_pkg: shared types and constants for the job scheduler
// Cell commands, policy codes and register indexes used by the queue cells
// and the control.
// ----------------------------------------------------------------------------
package jsch_pkg;

	localparam int ID_W   = 16;
	localparam int LEFT_W = 8;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_RR   = 2'd2;

	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic [LEFT_W-1:0] QUANTUM_RST = 8'd6;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_APPEND,
		OP_ROTATE,
		OP_SHIFT,
		OP_HEAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [ID_W-1:0]   new_id;
		logic [LEFT_W-1:0] new_left;
		logic [ID_W-1:0]   tail_id;
		logic [LEFT_W-1:0] tail_left;
	} cell_cmd_t;

	typedef struct packed {
		logic head;
		logic at_cnt;
		logic at_tail;
		logic below;
	} cell_pos_t;

endpackage

@@ hdl/jsch_cell.sv @@
// ----------------------------------------------------------------------------
// jsch_cell: one queue slot
// Holds one job id and remaining time; loads from the next slot, the new
// job or the tail value depending on the broadcast command.
// ----------------------------------------------------------------------------
module jsch_cell (
	input  logic                         clk,
	input  jsch_pkg::cell_cmd_t          cmd,
	input  jsch_pkg::cell_pos_t          pos,
	input  logic [jsch_pkg::ID_W-1:0]    nb_id,
	input  logic [jsch_pkg::LEFT_W-1:0]  nb_left,
	output logic [jsch_pkg::ID_W-1:0]    id,
	output logic [jsch_pkg::LEFT_W-1:0]  left
);

	logic [jsch_pkg::ID_W-1:0]   id_q;
	logic [jsch_pkg::LEFT_W-1:0] left_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			jsch_pkg::OP_APPEND: begin
				if (pos.at_cnt) begin
					id_q   <= cmd.new_id;
					left_q <= cmd.new_left;
				end
			end
			jsch_pkg::OP_ROTATE: begin
				if (pos.at_tail) begin
					id_q   <= cmd.tail_id;
					left_q <= cmd.tail_left;
				end else if (pos.below) begin
					id_q   <= nb_id;
					left_q <= nb_left;
				end
			end
			jsch_pkg::OP_SHIFT: begin
				id_q   <= nb_id;
				left_q <= nb_left;
			end
			jsch_pkg::OP_HEAD: begin
				if (pos.head) begin
					id_q   <= cmd.tail_id;
					left_q <= cmd.tail_left;
				end
			end
			default: begin
			end
		endcase
	end

	assign id   = id_q;
	assign left = left_q;

endmodule

@@ hdl/job_scheduler_fcfs_sjf_rr.sv @@
// ----------------------------------------------------------------------------
// job_scheduler_fcfs_sjf_rr: FCFS / SJF / round robin job scheduler
// Each item is one scheduler tick; each tick yields one status item.
// ----------------------------------------------------------------------------
// The job queue is a row of QUEUE_DEPTH cells with the running job in cell 0.
// Every queue update (append, drop of the head, rotation of head to tail) is
// one command broadcast to all cells. An arrival is appended at the tail
// directly under FCFS and round robin or into an empty queue; under SJF with a
// non-empty queue the insert walks the queue by rotating it once and appends
// the new job at the tail or ahead of the first waiting job whose remaining
// time is not less than its burst. A new item is taken while the previous
// result still waits in the output register; a result that is not taken holds
// back the next item's status.
module job_scheduler_fcfs_sjf_rr #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] arrival, [8:1] arrival_burst
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [0] idle, [16:1] running_id, [24:17] running_left,
	                               // [25] next_valid, [41:26] next_id, [49:42] next_left,
	                               // [50] job_created, [66:51] created_id,
	                               // [67] job_finished, [68] arrival_dropped
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = jsch_pkg::ID_W;
	localparam int LW = jsch_pkg::LEFT_W;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SERVE} state_t;

	state_t            state_q;
	logic [1:0]        policy_q;
	logic [LW-1:0]     quantum_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     corig_q;
	logic              ins_q;
	logic [IW-1:0]     idc_q;
	logic [LW-1:0]     slice_q;
	logic [LW-1:0]     burst_q;
	logic              created_q;
	logic [IW-1:0]     created_id_q;
	logic              dropped_q;
	logic              m_valid_q;
	logic [71:0]       m_data_q;

	logic [IW-1:0]     c_id   [QUEUE_DEPTH];
	logic [LW-1:0]     c_left [QUEUE_DEPTH];
	jsch_pkg::cell_cmd_t cmd;

	logic              rr;
	logic [LW-1:0]     q_eff;
	logic [LW-1:0]     dec;
	logic [LW-1:0]     slice_n;
	logic              out_free;
	logic              in_acc;
	logic              arr_in;
	logic [LW-1:0]     burst_in;
	logic              full;
	logic              arr_ok;
	logic              sjf_ins;
	logic              scan_done;
	logic              scan_hit;
	logic              serve_go;
	logic              do_rot;
	logic [71:0]       status;

	assign rr        = (policy_q == jsch_pkg::POL_RR);
	assign q_eff     = (quantum_q == '0) ? LW'(1) : quantum_q;
	assign dec       = (c_left[0] == '0) ? '0 : c_left[0] - LW'(1);
	assign slice_n   = (rr && slice_q != '1) ? slice_q + LW'(1) : slice_q;
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign arr_in    = s_tdata[0];
	assign burst_in  = s_tdata[8:1];
	assign full      = (cnt_q == CW'(QUEUE_DEPTH));
	assign arr_ok    = arr_in && !full;
	assign sjf_ins   = (policy_q == jsch_pkg::POL_SJF) && (cnt_q != '0);
	assign scan_done = (k_q == corig_q);
	assign scan_hit  = !ins_q && (k_q != '0) && (c_left[0] >= burst_q);
	assign serve_go  = (state_q == S_SERVE) && out_free;
	assign do_rot    = rr && (slice_n >= q_eff);

	always_comb begin
		cmd.op        = jsch_pkg::OP_HOLD;
		cmd.new_id    = idc_q;
		cmd.new_left  = burst_in;
		cmd.tail_id   = c_id[0];
		cmd.tail_left = c_left[0];
		case (state_q)
			S_IDLE: begin
				if (in_acc && arr_in && !full &&
				    !(policy_q == jsch_pkg::POL_SJF && cnt_q != '0))
					cmd.op = jsch_pkg::OP_APPEND;
			end
			S_SCAN: begin
				cmd.new_id   = created_id_q;
				cmd.new_left = burst_q;
				if (scan_done) begin
					if (!ins_q)
						cmd.op = jsch_pkg::OP_APPEND;
				end else if (scan_hit) begin
					cmd.op = jsch_pkg::OP_APPEND;
				end else begin
					cmd.op = jsch_pkg::OP_ROTATE;
				end
			end
			S_SERVE: begin
				cmd.tail_left = dec;
				if (out_free && cnt_q != '0) begin
					if (dec == '0)
						cmd.op = jsch_pkg::OP_SHIFT;
					else if (do_rot)
						cmd.op = jsch_pkg::OP_ROTATE;
					else
						cmd.op = jsch_pkg::OP_HEAD;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status         = '0;
		status[50]     = created_q;
		status[66:51]  = created_id_q;
		status[68]     = dropped_q;
		if (cnt_q == '0) begin
			status[0] = 1'b1;
		end else begin
			status[16:1]  = c_id[0];
			status[24:17] = dec;
			if (cnt_q >= CW'(2)) begin
				status[25]    = 1'b1;
				status[41:26] = c_id[1];
				status[49:42] = c_left[1];
			end
			status[67] = (dec == '0);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		jsch_pkg::cell_pos_t pos;
		logic [IW-1:0] nb_id;
		logic [LW-1:0] nb_left;

		assign pos.head    = (i == 0);
		assign pos.at_cnt  = (cnt_q == CW'(i));
		assign pos.at_tail = (cnt_q == CW'(i + 1));
		assign pos.below   = (cnt_q > CW'(i + 1));

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nb_id   = '0;
			assign nb_left = '0;
		end else begin : g_mid
			assign nb_id   = c_id[i + 1];
			assign nb_left = c_left[i + 1];
		end

		jsch_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.pos     (pos),
			.nb_id   (nb_id),
			.nb_left (nb_left),
			.id      (c_id[i]),
			.left    (c_left[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= jsch_pkg::POL_FCFS;
			quantum_q    <= jsch_pkg::QUANTUM_RST;
			cnt_q        <= '0;
			k_q          <= '0;
			corig_q      <= '0;
			ins_q        <= 1'b0;
			idc_q        <= IW'(1);
			slice_q      <= '0;
			burst_q      <= '0;
			created_q    <= 1'b0;
			created_id_q <= '0;
			dropped_q    <= 1'b0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == jsch_pkg::REG_POLICY)
					policy_q <= cfg_wdata[1:0];
				else
					quantum_q <= cfg_wdata;
			end
			if (serve_go)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						burst_q      <= burst_in;
						created_q    <= arr_ok;
						created_id_q <= arr_ok ? idc_q : '0;
						dropped_q    <= arr_in && full;
						if (!rr)
							slice_q <= '0;
						if (arr_ok) begin
							idc_q <= idc_q + IW'(1);
							if (sjf_ins) begin
								k_q     <= '0;
								corig_q <= cnt_q;
								ins_q   <= 1'b0;
								state_q <= S_SCAN;
							end else begin
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_SERVE;
							end
						end else begin
							state_q <= S_SERVE;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (!ins_q)
							cnt_q <= cnt_q + CW'(1);
						state_q <= S_SERVE;
					end else if (scan_hit) begin
						ins_q <= 1'b1;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_SERVE: begin
					if (out_free) begin
						m_data_q <= status;
						if (cnt_q != '0) begin
							if (dec == '0) begin
								cnt_q   <= cnt_q - CW'(1);
								slice_q <= '0;
							end else if (do_rot) begin
								slice_q <= '0;
							end else begin
								slice_q <= slice_n;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_finish_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(serve_go && cnt_q != '0 && dec == '0) |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("finished head not removed");

	a_idle_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (!m_tdata[67] && !m_tdata[25]))
		else $error("idle result with served job");

	a_create_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[50] && m_tdata[68]))
		else $error("arrival both created and dropped");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (k_q <= corig_q && corig_q != '0))
		else $error("insert scan out of range");

endmodule
